/* design/vfd_pkg.sv */
// Shared types, constants and the CRC-8 byte update for the velocity frame deframer.
// No dependencies; the files of the block other than vfd_if.sv refer to this package by scoped name.

package vfd_pkg;

    // Reset values of the header byte registers.
    localparam logic [7:0] SYNC_FIRST_RESET  = 8'h55;
    localparam logic [7:0] SYNC_SECOND_RESET = 8'hAA;

    // Reflected CRC-8 polynomial; the CRC restarts from zero for every frame.
    localparam logic [7:0] CRC_POLY = 8'h8C;
    localparam logic [7:0] CRC_INIT = 8'h00;

    // Default for the largest payload length that is accepted.
    localparam int MAX_PAYLOAD_DEFAULT = 32;

    // Number of payload bytes that are captured into the four value fields.
    localparam int FIELD_BYTES = 8;

    // Register indexes on the configuration port.
    localparam logic REG_SYNC_FIRST  = 1'b0;
    localparam logic REG_SYNC_SECOND = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CRC   = 2'd1,
        ST_SHORT = 2'd2,
        ST_LONG  = 2'd3
    } frame_status_t;

    // One byte of the reflected CRC, eight shift steps on an 8-bit value.
    function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

/* design/vfd_if.sv */
// Handshake channel interfaces of the velocity frame deframer: received bytes in, frames out.
// Depends on nothing but the width of the fields; no package is needed here.

interface vfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface vfd_frame_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  frame_status;
    logic signed [15:0] x_velocity;
    logic signed [15:0] y_velocity;
    logic signed [15:0] turn_rate;
    logic signed [15:0] heading_angle;

    modport source (
        output valid, output frame_status, output x_velocity, output y_velocity,
        output turn_rate, output heading_angle, input ready
    );
    modport sink (
        input valid, input frame_status, input x_velocity, input y_velocity,
        input turn_rate, input heading_angle, output ready
    );
endinterface

/* design/velocity_frame_deframer_crc8.sv */
// Top level of the velocity frame deframer: header hunt, length and payload parsing, CRC-8.
// Depends on vfd_pkg and on the channel interfaces in vfd_if.sv.
//
// The deframer takes one received byte per transaction on the rx channel and can accept a
// byte in every clock cycle unless stalled, so its sustained rate is one byte per cycle. Each
// byte is parsed in the cycle in which it is accepted: the CRC update and the phase decision
// sit between the parse state registers and a single result register, so a frame result is
// offered on the frame channel in the cycle after its check byte (or its over-long length
// byte) has been accepted. The result register is the only buffering: while a result waits
// to be taken, a further byte is accepted in the same cycle in which the waiting result
// leaves, and is held off only while the result is stalled. The block hunts for the two
// header bytes held in the sync_first and sync_second registers; a repeated first header byte
// restarts the header. The byte after the header is the payload length, then come that many
// payload bytes and one check byte. A reflected CRC-8 (polynomial 0x8C, starting from zero,
// no final inversion) runs over header, length and payload, and is compared with the check
// byte. The first eight payload bytes give four signed 16-bit values, low byte first; they
// are reported only with an ok status and are zero otherwise. A length above MAX_PAYLOAD
// reports a too-long status at once without waiting for a check byte. After every result
// the block goes back to hunting for the header. The header registers are written over an
// APB-style port at byte addresses 0 and 4 and take effect at the next header compare.

module velocity_frame_deframer_crc8 #(
    parameter int MAX_PAYLOAD = vfd_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,

    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    // Received bytes and frame results.
    vfd_rx_if.sink             rx,
    vfd_frame_if.source        frame
);

    // Length limit at the width of the length byte.
    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4
    } phase_t;

    // Configuration registers.
    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;
    logic       cfg_write;

    // Parse state.
    phase_t     phase_reg,  phase_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] pos_reg,    pos_next;
    logic [7:0] crc_reg,    crc_next;
    logic [63:0] cap_reg,   cap_next;

    // Result register.
    logic                  out_valid_reg;
    vfd_pkg::frame_status_t status_reg, status_next;
    logic [63:0]           fields_reg, fields_next;
    logic                  emit;

    logic       rx_fire;
    logic [7:0] rx_data;
    logic [7:0] crc_step;
    logic [7:0] pos_inc;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access cycle; the port
    // never inserts wait states. Only address bit 2 selects a register.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= vfd_pkg::SYNC_FIRST_RESET;
            sync_second_reg <= vfd_pkg::SYNC_SECOND_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                vfd_pkg::REG_SYNC_FIRST:  sync_first_reg  <= pwdata[7:0];
                vfd_pkg::REG_SYNC_SECOND: sync_second_reg <= pwdata[7:0];
                default:                  sync_first_reg  <= sync_first_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            vfd_pkg::REG_SYNC_FIRST:  prdata = {24'd0, sync_first_reg};
            vfd_pkg::REG_SYNC_SECOND: prdata = {24'd0, sync_second_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake. A byte is taken whenever the result register is empty or
    // its result leaves in this cycle, so back-to-back bytes flow freely.
    // ------------------------------------------------------------------
    assign rx.ready = ~out_valid_reg | frame.ready;
    assign rx_fire  = rx.valid & rx.ready;
    assign rx_data  = rx.rx_byte;

    // The CRC over the running value; the header restart uses its own start value.
    assign crc_step = vfd_pkg::crc8_update(crc_reg, rx_data);
    assign pos_inc  = pos_reg + 8'd1;

    // ------------------------------------------------------------------
    // Per-byte parse. Everything here acts on the accepted byte only.
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        cap_next    = cap_reg;
        emit        = 1'b0;
        status_next = vfd_pkg::ST_OK;
        fields_next = 64'd0;

        if (rx_fire)
        begin
            unique case (phase_reg)
                PH_HUNT2:
                begin
                    if (rx_data == sync_second_reg)
                    begin
                        crc_next   = crc_step;
                        phase_next = PH_LENGTH;
                    end
                    else if (rx_data == sync_first_reg)
                    begin
                        // A repeated first header byte starts the header afresh.
                        crc_next = vfd_pkg::crc8_update(vfd_pkg::CRC_INIT, rx_data);
                    end
                    else
                    begin
                        phase_next = PH_HUNT1;
                        crc_next   = vfd_pkg::CRC_INIT;
                    end
                end

                PH_LENGTH:
                begin
                    crc_next = crc_step;
                    cap_next = 64'd0;
                    pos_next = 8'd0;
                    if (rx_data > MAX_LEN)
                    begin
                        // Over-long frames are reported straight away.
                        length_next = 8'd0;
                        phase_next  = PH_HUNT1;
                        crc_next    = vfd_pkg::CRC_INIT;
                        emit        = 1'b1;
                        status_next = vfd_pkg::ST_LONG;
                    end
                    else
                    begin
                        length_next = rx_data;
                        phase_next  = (rx_data == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end

                PH_PAYLOAD:
                begin
                    crc_next = crc_step;
                    if (pos_reg[7:3] == 5'd0)
                    begin
                        cap_next[{pos_reg[2:0], 3'b000} +: 8] = rx_data;
                    end
                    pos_next = pos_inc;
                    if (pos_inc >= length_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end

                PH_CHECK:
                begin
                    emit = 1'b1;
                    if (crc_reg != rx_data)
                    begin
                        status_next = vfd_pkg::ST_CRC;
                    end
                    else if (length_reg < 8'(vfd_pkg::FIELD_BYTES))
                    begin
                        status_next = vfd_pkg::ST_SHORT;
                    end
                    else
                    begin
                        status_next = vfd_pkg::ST_OK;
                        fields_next = cap_reg;
                    end
                    phase_next  = PH_HUNT1;
                    crc_next    = vfd_pkg::CRC_INIT;
                    cap_next    = 64'd0;
                    length_next = 8'd0;
                    pos_next    = 8'd0;
                end

                default:
                begin
                    // Hunting for the first header byte; unused codes behave the same.
                    if (rx_data == sync_first_reg)
                    begin
                        crc_next   = vfd_pkg::crc8_update(vfd_pkg::CRC_INIT, rx_data);
                        phase_next = PH_HUNT2;
                    end
                    else
                    begin
                        crc_next   = vfd_pkg::CRC_INIT;
                        phase_next = PH_HUNT1;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // State and result registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT1;
            length_reg    <= 8'd0;
            pos_reg       <= 8'd0;
            crc_reg       <= vfd_pkg::CRC_INIT;
            cap_reg       <= 64'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            cap_reg    <= cap_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (frame.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The result payload needs no reset; it is only looked at while valid.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg <= status_next;
            fields_reg <= fields_next;
        end
    end

    assign frame.valid         = out_valid_reg;
    assign frame.frame_status  = status_reg;
    assign frame.x_velocity    = fields_reg[15:0];
    assign frame.y_velocity    = fields_reg[31:16];
    assign frame.turn_rate     = fields_reg[47:32];
    assign frame.heading_angle = fields_reg[63:48];

endmodule

/* design/vfd_checker.sv */
// Port-level checker for the velocity frame deframer, with the bind that attaches it.
// Depends on vfd_pkg and on the ports of velocity_frame_deframer_crc8.

module vfd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               rx_valid,
    input logic               rx_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic        [1:0]  frame_status,
    input logic signed [15:0] x_velocity,
    input logic signed [15:0] y_velocity,
    input logic signed [15:0] turn_rate,
    input logic signed [15:0] heading_angle
);

    // A stalled result stays offered.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("frame result dropped while stalled");

    // Input is never held off while no result is pending.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> rx_ready)
        else $error("rx held off with an empty result register");

    // A new result needs a byte accepted in the cycle before.
    a_result_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(rx_valid && rx_ready))
        else $error("frame result appeared without an accepted byte");

    // A taken result without a fresh byte leaves the channel empty.
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !(rx_valid && rx_ready) |=> !out_valid)
        else $error("frame result repeated");

    // Values are reported only with an ok status.
    a_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_status != 2'(vfd_pkg::ST_OK)) |->
            (x_velocity == 16'sd0) && (y_velocity == 16'sd0) &&
            (turn_rate == 16'sd0) && (heading_angle == 16'sd0))
        else $error("values reported with a failing status");

endmodule

bind velocity_frame_deframer_crc8 vfd_checker u_vfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_valid      (rx.valid),
    .rx_ready      (rx.ready),
    .out_valid     (frame.valid),
    .out_ready     (frame.ready),
    .frame_status  (frame.frame_status),
    .x_velocity    (frame.x_velocity),
    .y_velocity    (frame.y_velocity),
    .turn_rate     (frame.turn_rate),
    .heading_angle (frame.heading_angle)
);

/* sim/velocity_frame_deframer_crc8_tb.sv */
// Self-checking testbench for the velocity frame deframer: byte stream in, frame results out.
// Depends on vfd_pkg, the channel interfaces in vfd_if.sv and the deframer top level.
// Holds its own parser and CRC-8 to predict each frame result and compares them field by field.
`timescale 1ns / 1ps

module velocity_frame_deframer_crc8_tb;

    // The largest payload length accepted by the instance under test.
    localparam int MAX_LEN = vfd_pkg::MAX_PAYLOAD_DEFAULT;

    // Cycles let pass before a register write once the last result has arrived. A byte is
    // parsed in the cycle in which it is accepted, so a handful of cycles is ample.
    localparam int SETTLE_CYCLES = 4;

    // Long receiver hold-off, started once enough bytes have gone in.
    localparam int HOLD_AT     = 900;
    localparam int HOLD_CYCLES = 400;

    // Bound on the wait for outstanding results at the end of the run.
    localparam int DRAIN_LIMIT = 2000;

    // Overall limit on the run, far above the slowest correct run.
    localparam int TIMEOUT_NS = 4_000_000;

    // Phases of our own parser. Codes not listed fall back to hunting for the first byte.
    typedef enum logic [2:0] {
        SEEK_FIRST,
        SEEK_SECOND,
        TAKE_LENGTH,
        TAKE_PAYLOAD,
        TAKE_CHECK
    } parser_phase_t;

    // One expected frame result.
    typedef struct {
        vfd_pkg::frame_status_t status;
        logic signed [15:0]     vx;
        logic signed [15:0]     vy;
        logic signed [15:0]     turn;
        logic signed [15:0]     heading;
    } frame_rec_t;

    logic        clk = 1'b0;
    logic        rst_n;

    // Configuration port; idle from the very start of the run.
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    vfd_rx_if    rx_ch ();
    vfd_frame_if frame_ch ();

    velocity_frame_deframer_crc8 #(
        .MAX_PAYLOAD (MAX_LEN)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rx      (rx_ch),
        .frame   (frame_ch)
    );

    // Header bytes as currently programmed into the block.
    logic [7:0]    hdr_first  = vfd_pkg::SYNC_FIRST_RESET;
    logic [7:0]    hdr_second = vfd_pkg::SYNC_SECOND_RESET;

    // Our copy of the parser state.
    parser_phase_t phase      = SEEK_FIRST;
    logic [7:0]    frame_len  = '0;
    logic [7:0]    pay_idx    = '0;
    logic [7:0]    crc_acc    = vfd_pkg::CRC_INIT;
    logic [63:0]   pay_bytes  = '0;

    // Bytes waiting to be offered, and frame results still to come from the block.
    logic [7:0]    rx_pending[$];
    frame_rec_t    expected_frames[$];

    // Scratch payload used while building frames.
    logic [7:0]    frame_body[$];

    // Idling switches per phase of the run.
    bit            sender_idle   = 1'b1;
    bit            receiver_idle = 1'b1;

    int unsigned   gap_left;
    int unsigned   stall_left;
    int unsigned   hold_left;
    bit            hold_done;
    int unsigned   bytes_accepted;
    int unsigned   bytes_queued   = 0;
    int unsigned   settings_count = 0;
    int unsigned   status_seen[4] = '{0, 0, 0, 0};
    int unsigned   mismatches     = 0;

    // Clock: 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Reflected CRC-8, worked one data bit at a time, least significant bit first. This is
    // the bit-serial form of the byte update and gives the same value.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int k = 0; k < 8; k++)
        begin
            fb = c[0] ^ data[k];
            c  = c >> 1;
            if (fb)
                c = c ^ vfd_pkg::CRC_POLY;
        end
        return c;
    endfunction

    // Number of cycles one side waits before its next transaction. Roughly four in ten draws
    // are zero so that back-to-back stretches occur even with idling switched on.
    function automatic int unsigned draw_wait(input bit enabled);
        if (!enabled || $urandom_range(0, 9) < 4)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    // Advances our parser by one accepted byte and files the frame result it causes, if any.
    function automatic void parse_byte(input logic [7:0] b);
        frame_rec_t             rec;
        vfd_pkg::frame_status_t st;
        bit                     done;
        done = 1'b0;
        unique case (phase)
            SEEK_SECOND:
            begin
                if (b == hdr_second)
                begin
                    crc_acc = crc8_step(crc_acc, b);
                    phase   = TAKE_LENGTH;
                end
                else if (b == hdr_first)
                begin
                    // A repeated first byte starts the header over.
                    crc_acc = crc8_step(vfd_pkg::CRC_INIT, b);
                end
                else
                begin
                    crc_acc = vfd_pkg::CRC_INIT;
                    phase   = SEEK_FIRST;
                end
            end
            TAKE_LENGTH:
            begin
                crc_acc   = crc8_step(crc_acc, b);
                pay_bytes = '0;
                pay_idx   = '0;
                if (int'(b) > MAX_LEN)
                begin
                    // Too long: reported at once, no check byte follows.
                    frame_len = '0;
                    crc_acc   = vfd_pkg::CRC_INIT;
                    phase     = SEEK_FIRST;
                    st        = vfd_pkg::ST_LONG;
                    done      = 1'b1;
                end
                else
                begin
                    frame_len = b;
                    phase     = (b == 8'd0) ? TAKE_CHECK : TAKE_PAYLOAD;
                end
            end
            TAKE_PAYLOAD:
            begin
                crc_acc = crc8_step(crc_acc, b);
                // Bytes past the eighth only feed the CRC.
                if (pay_idx < vfd_pkg::FIELD_BYTES)
                    pay_bytes[8 * pay_idx +: 8] = b;
                pay_idx = pay_idx + 8'd1;
                if (pay_idx >= frame_len)
                    phase = TAKE_CHECK;
            end
            TAKE_CHECK:
            begin
                // A CRC mismatch takes precedence over a short payload.
                if (crc_acc != b)
                    st = vfd_pkg::ST_CRC;
                else if (frame_len < vfd_pkg::FIELD_BYTES)
                    st = vfd_pkg::ST_SHORT;
                else
                    st = vfd_pkg::ST_OK;
                if (st != vfd_pkg::ST_OK)
                    pay_bytes = '0;
                done = 1'b1;
            end
            default:
            begin
                if (b == hdr_first)
                begin
                    crc_acc = crc8_step(vfd_pkg::CRC_INIT, b);
                    phase   = SEEK_SECOND;
                end
                else
                begin
                    crc_acc = vfd_pkg::CRC_INIT;
                    phase   = SEEK_FIRST;
                end
            end
        endcase
        if (done)
        begin
            rec.status  = st;
            rec.vx      = pay_bytes[15:0];
            rec.vy      = pay_bytes[31:16];
            rec.turn    = pay_bytes[47:32];
            rec.heading = pay_bytes[63:48];
            expected_frames.push_back(rec);
            if (phase == TAKE_CHECK)
            begin
                phase     = SEEK_FIRST;
                crc_acc   = vfd_pkg::CRC_INIT;
                frame_len = '0;
                pay_idx   = '0;
            end
            pay_bytes = '0;
        end
    endfunction

    function automatic void compare_field(input string label, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, label, $signed(want), $signed(got));
        end
    endfunction

    // Byte driver. A new byte is put up once the previous transaction has completed and the
    // drawn gap has run out; the prediction is made at the edge of the transaction itself.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ch.valid    <= 1'b0;
            rx_ch.rx_byte  <= '0;
            gap_left       <= 0;
            bytes_accepted <= 0;
        end
        else
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                parse_byte(rx_ch.rx_byte);
                bytes_accepted <= bytes_accepted + 1;
            end
            if (!rx_ch.valid || rx_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    rx_ch.valid <= 1'b0;
                    gap_left    <= gap_left - 1;
                end
                else if (rx_pending.size() != 0)
                begin
                    rx_ch.valid   <= 1'b1;
                    rx_ch.rx_byte <= rx_pending.pop_front();
                    gap_left      <= draw_wait(sender_idle);
                end
                else
                begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off on the result side, counted here so that the receiver keeps its own
    // per-result stalls. While it runs the sender keeps offering bytes, so the single result
    // register fills and the block has to stall its byte input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && bytes_accepted >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Result monitor. Every frame transaction is matched against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        int unsigned n;
        frame_rec_t  want;
        if (!rst_n)
        begin
            frame_ch.ready <= 1'b0;
            stall_left     <= 0;
        end
        else
        begin
            n = stall_left;
            if (frame_ch.valid && frame_ch.ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected frame, expected none, actual status %0d",
                             $time, frame_ch.frame_status);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    status_seen[want.status]++;
                    compare_field("frame_status", 16'(want.status),
                                  16'(frame_ch.frame_status));
                    compare_field("x_velocity", want.vx, frame_ch.x_velocity);
                    compare_field("y_velocity", want.vy, frame_ch.y_velocity);
                    compare_field("turn_rate", want.turn, frame_ch.turn_rate);
                    compare_field("heading_angle", want.heading, frame_ch.heading_angle);
                end
                n = draw_wait(receiver_idle);
            end
            else if (n != 0)
            begin
                n--;
            end
            stall_left     <= n;
            frame_ch.ready <= (n == 0) && (hold_left == 0);
        end
    end

    task automatic offer_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        bytes_queued++;
    endtask

    // Queues a complete frame around frame_body under the current header bytes. The check
    // byte is the true CRC exclusive-or flip, so a non-zero flip always gives a mismatch.
    task automatic queue_frame(input logic [7:0] flip);
        logic [7:0] crc;
        logic [7:0] len;
        len = 8'(frame_body.size());
        crc = crc8_step(crc8_step(crc8_step(vfd_pkg::CRC_INIT, hdr_first), hdr_second), len);
        offer_byte(hdr_first);
        offer_byte(hdr_second);
        offer_byte(len);
        foreach (frame_body[k])
        begin
            crc = crc8_step(crc, frame_body[k]);
            offer_byte(frame_body[k]);
        end
        offer_byte(crc ^ flip);
    endtask

    task automatic fill_body(input int len);
        frame_body.delete();
        repeat (len)
            frame_body.push_back(8'($urandom_range(0, 255)));
    endtask

    // Payload lengths for full-size frames: mostly the minimum, sometimes longer, now and
    // then the largest accepted.
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return MAX_LEN;
        if (r <= 3)
            return $urandom_range(vfd_pkg::FIELD_BYTES + 1, MAX_LEN - 1);
        return vfd_pkg::FIELD_BYTES;
    endfunction

    // Random traffic: mostly well-formed frames with random content, the rest bad checks,
    // over-long lengths, short payloads, broken headers and line noise.
    task automatic queue_random_traffic(input int unsigned count);
        int unsigned start;
        int          kind;
        logic [7:0]  b;
        start = bytes_queued;
        while (bytes_queued - start < count)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 50)
            begin
                fill_body(pick_length());
                queue_frame(8'h00);
            end
            else if (kind < 65)
            begin
                fill_body(pick_length());
                queue_frame(8'($urandom_range(1, 255)));
            end
            else if (kind < 73)
            begin
                offer_byte(hdr_first);
                offer_byte(hdr_second);
                if ($urandom_range(0, 3) == 0)
                    offer_byte(8'hFF);
                else
                    offer_byte(8'($urandom_range(MAX_LEN + 1, 255)));
            end
            else if (kind < 85)
            begin
                fill_body($urandom_range(0, vfd_pkg::FIELD_BYTES - 1));
                queue_frame($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255)));
            end
            else if (kind < 93)
            begin
                // First header byte, perhaps repeated, then something other than the second.
                repeat ($urandom_range(1, 3))
                    offer_byte(hdr_first);
                b = 8'($urandom_range(0, 255));
                if (b == hdr_second)
                    b = b ^ 8'h01;
                offer_byte(b);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    offer_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // APB write: setup cycle, then access cycle; the register takes the value at the edge
    // at which the access completes.
    task automatic write_reg(input logic idx, input logic [7:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == vfd_pkg::REG_SYNC_FIRST)
            hdr_first = value;
        else
            hdr_second = value;
    endtask

    task automatic apply_headers(input logic [7:0] first, input logic [7:0] second);
        write_reg(vfd_pkg::REG_SYNC_FIRST, first);
        write_reg(vfd_pkg::REG_SYNC_SECOND, second);
        settings_count++;
    endtask

    // Waits until every queued byte has gone in and every expected result has come out,
    // then lets the parser come to rest before the configuration is touched.
    task automatic settle();
        do
            @(negedge clk);
        while (rx_pending.size() != 0 || rx_ch.valid || expected_frames.size() != 0);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned waited;
        rst_n = 1'b0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames under the reset header bytes. First a good frame whose values hit
        // the most negative, the most positive, minus one and plus one.
        frame_body = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'h01, 8'h00};
        queue_frame(8'h00);
        // Repeated first header byte, then a zero length so that the next byte is the check;
        // the CRC matches, so the frame is reported as short.
        offer_byte(hdr_first);
        frame_body.delete();
        queue_frame(8'h00);
        // The largest length byte: reported as too long straight away.
        offer_byte(hdr_first);
        offer_byte(hdr_second);
        offer_byte(8'hFF);
        // Short payload with a bad check byte: the mismatch must win.
        frame_body = '{8'h3C};
        queue_frame(8'h01);
        settle();

        // Random phases, each under its own header bytes and idling pattern.
        apply_headers(8'h00, 8'hFF);
        queue_random_traffic(265);
        settle();

        sender_idle = 1'b0;
        apply_headers(8'hFF, 8'h00);
        queue_random_traffic(265);
        settle();

        // This phase stops right after a first header byte, so the write below lands while
        // the block waits for the second one.
        sender_idle = 1'b1;
        apply_headers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        queue_random_traffic(265);
        offer_byte(hdr_first);
        settle();

        // Both header bytes equal; this phase stops in the middle of a payload, and the next
        // phase's bytes complete that frame.
        receiver_idle = 1'b0;
        apply_headers(8'h5A, 8'h5A);
        queue_random_traffic(265);
        offer_byte(hdr_first);
        offer_byte(hdr_second);
        offer_byte(8'd10);
        repeat (4)
            offer_byte(8'($urandom_range(0, 255)));
        settle();

        // No idling on either side.
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        apply_headers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        queue_random_traffic(265);
        settle();

        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        apply_headers(vfd_pkg::SYNC_FIRST_RESET, vfd_pkg::SYNC_SECOND_RESET);
        queue_random_traffic(265);

        // End of run: all bytes in, then a bounded wait for the last results.
        while (rx_pending.size() != 0 || rx_ch.valid)
            @(negedge clk);
        waited = 0;
        while (expected_frames.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (16)
            @(negedge clk);
        if (expected_frames.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d frame results never arrived, oldest expected status %0d",
                     $time, expected_frames.size(), expected_frames[0].status);
        end

        $display("Run covered %0d bytes under %0d header settings, with a %0d-cycle hold-off.",
                 bytes_accepted, settings_count, HOLD_CYCLES);
        $display("Frames checked: %0d ok, %0d check error, %0d short, %0d too long.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (mismatches == 0)
            $display("velocity_frame_deframer_crc8_tb passed");
        else
            $display("velocity_frame_deframer_crc8_tb failed");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("%0t: timeout", $time);
        $display("velocity_frame_deframer_crc8_tb failed");
        $finish;
    end

endmodule
